[hdl/ddm_pkg.sv]
// ----------------------------------------------------------------------------
// ddm_pkg
// Shared types and constants for the differential drive mixer.
// ----------------------------------------------------------------------------
package ddm_pkg;

  // Default pivot turn amount; commands saturate to twice this value.
  localparam int PIVOT_DEFAULT = 50;

  // Field widths.
  localparam int CMD_W       = 8;   // signed speed and turn commands
  localparam int MAG_W       = 8;   // saturated command magnitude, up to 128
  localparam int WHEEL_W     = 7;   // wheel speed output
  localparam int DZ_W        = 6;   // dead zone register
  localparam int NUM_W       = 15;  // dividend of the divide by the pivot

  localparam logic [DZ_W-1:0] DEAD_ZONE_RESET = 6'd5;

  // Mixing mode chosen in the first stage.
  typedef enum logic [1:0] {
    MODE_STRAIGHT,
    MODE_SPIN,
    MODE_SLOW,
    MODE_REVERSE
  } mix_mode_t;

  // Contents of the first pipeline stage.
  typedef struct packed {
    mix_mode_t        mode;
    logic [MAG_W-1:0] speed;
    logic [MAG_W-1:0] turn;
    logic             turn_right;
    logic             forward;
    logic [NUM_W-1:0] dividend;
  } mix_stage_t;

endpackage

[hdl/differential_drive_mixer_core.sv]
// ----------------------------------------------------------------------------
// differential_drive_mixer_core
// Arcade-style mixing of a speed and a turn command into wheel speeds and
// directions for a two-motor differential drive, with change flags.
// ----------------------------------------------------------------------------
//
// Channel     Dir  Bits  Contents (lowest bit first)
// s_axis      in   16    speed_command[7:0], turn_command[15:8]
// m_axis      out  24    left_speed[6:0], left_forward[7], right_speed[14:8],
//                        right_forward[15], left_speed_changed[16],
//                        left_dir_changed[17], right_speed_changed[18],
//                        right_dir_changed[19], zero fill[23:20]
// dead_zone   in   6     write enable plus write data, no read-back
//
// One transaction is accepted every clock cycle while the first stage has room. A
// command is registered in the first stage and its result in the output
// register, from which it is offered on m_axis. The first
// stage saturates the commands, picks the mixing mode and forms the product
// for the inner wheel; the second stage divides by the pivot through a
// reciprocal multiply and registers the result together with its change flags.
// Reset (rst, synchronous) empties both stages, restores the dead zone to 5
// and clears the history so the first result flags all four outputs.
// When m_axis_tready is low, the output register holds and the first stage
// keeps accepting until it fills too; nothing is dropped or repeated.
//
module differential_drive_mixer_core
  import ddm_pkg::*;
#(
  parameter int PIVOT = PIVOT_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  // Dead zone register write.
  input  logic            dead_zone_wr_en,
  input  logic [DZ_W-1:0] dead_zone_wr_data,
  // Command input: speed_command [7:0], turn_command [15:8].
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [15:0]     s_axis_tdata,
  // Result: left_speed [6:0], left_forward [7], right_speed [14:8],
  // right_forward [15], left_speed_changed [16], left_dir_changed [17],
  // right_speed_changed [18], right_dir_changed [19], zeros [23:20].
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [23:0]     m_axis_tdata
);

  // Saturation limit for both commands, in a width that holds 2*PIVOT and
  // the sign-extended 8-bit command alike.
  localparam logic signed [9:0] CmdLimit = 10'(2 * PIVOT);
  localparam logic [MAG_W-1:0]  PivotMag = MAG_W'(PIVOT);
  localparam logic [NUM_W-1:0]  RoundUp  = NUM_W'(PIVOT - 1);

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [DZ_W-1:0] dead_zone;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_zone <= DEAD_ZONE_RESET;
    end else if (dead_zone_wr_en) begin
      dead_zone <= dead_zone_wr_data;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: two stages, each advancing when the one after it has room.
  // --------------------------------------------------------------------------
  logic       stage_valid;
  logic       stage_ready;
  logic       out_ready;
  logic       stage_load;
  logic       out_load;

  assign out_ready     = !m_axis_tvalid || m_axis_tready;
  assign stage_ready   = !stage_valid || out_ready;
  assign s_axis_tready = stage_ready;
  assign stage_load    = s_axis_tvalid && stage_ready;
  assign out_load      = stage_valid && out_ready;

  // --------------------------------------------------------------------------
  // Stage 1: saturate, take magnitudes, choose the mode and multiply.
  // --------------------------------------------------------------------------
  logic signed [9:0]  speed_wide;
  logic signed [9:0]  turn_wide;
  logic signed [9:0]  speed_sat;
  logic signed [9:0]  turn_sat;
  logic [MAG_W-1:0]   speed_mag;
  logic [MAG_W-1:0]   turn_mag;
  logic [MAG_W-1:0]   mul_turn;
  logic [2*MAG_W-1:0] mul_product;
  logic [MAG_W-1:0]   dead_zone_mag;
  mix_stage_t         stage_next;
  mix_stage_t         stage;

  assign speed_wide    = 10'(signed'(s_axis_tdata[7:0]));
  assign turn_wide     = 10'(signed'(s_axis_tdata[15:8]));
  assign dead_zone_mag = MAG_W'(dead_zone);

  always_comb begin
    if (speed_wide > CmdLimit) begin
      speed_sat = CmdLimit;
    end else if (speed_wide < -CmdLimit) begin
      speed_sat = -CmdLimit;
    end else begin
      speed_sat = speed_wide;
    end
    if (turn_wide > CmdLimit) begin
      turn_sat = CmdLimit;
    end else if (turn_wide < -CmdLimit) begin
      turn_sat = -CmdLimit;
    end else begin
      turn_sat = turn_wide;
    end
  end

  // The saturated commands never exceed 128 in magnitude.
  assign speed_mag = speed_sat[9] ? MAG_W'(-speed_sat) : MAG_W'(speed_sat);
  assign turn_mag  = turn_sat[9]  ? MAG_W'(-turn_sat)  : MAG_W'(turn_sat);

  always_comb begin
    stage_next            = '0;
    stage_next.speed      = speed_mag;
    stage_next.turn       = turn_mag;
    stage_next.turn_right = !turn_sat[9] && (turn_sat != '0);
    stage_next.forward    = !speed_sat[9];

    if (speed_mag < dead_zone_mag && turn_mag > dead_zone_mag) begin
      stage_next.mode = MODE_SPIN;
    end else if (turn_mag > dead_zone_mag) begin
      stage_next.mode = (turn_mag < PivotMag) ? MODE_SLOW : MODE_REVERSE;
    end else begin
      stage_next.mode = MODE_STRAIGHT;
    end

    // The slowed wheel needs ceil(turn*speed/PIVOT), so the dividend gets
    // PIVOT-1 added; the reversed wheel needs floor((turn-PIVOT)*speed/PIVOT).
    mul_turn    = (stage_next.mode == MODE_SLOW) ? turn_mag : turn_mag - PivotMag;
    mul_product = mul_turn * speed_mag;
    if (stage_next.mode == MODE_SLOW) begin
      stage_next.dividend = NUM_W'(mul_product) + RoundUp;
    end else begin
      stage_next.dividend = NUM_W'(mul_product);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stage_ready) begin
      stage_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_load) begin
      stage <= stage_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: divide by the pivot, assign wheels, saturate, compare history.
  // --------------------------------------------------------------------------
  logic [NUM_W-1:0]   quotient;
  logic [MAG_W-1:0]   inner;
  logic [MAG_W-1:0]   left_mag;
  logic [MAG_W-1:0]   right_mag;
  logic [WHEEL_W-1:0] left_speed_next;
  logic [WHEEL_W-1:0] right_speed_next;
  logic               left_fwd_next;
  logic               right_fwd_next;

  ddm_const_div #(
    .Divisor (PIVOT),
    .NumW    (NUM_W)
  ) u_div (
    .dividend (stage.dividend),
    .quotient (quotient)
  );

  // The quotient is at most the speed magnitude in both modes that use it.
  assign inner = (stage.mode == MODE_SLOW) ? stage.speed - MAG_W'(quotient)
                                           : MAG_W'(quotient);

  always_comb begin
    left_mag       = stage.speed;
    right_mag      = stage.speed;
    left_fwd_next  = stage.forward;
    right_fwd_next = stage.forward;
    unique case (stage.mode)
      MODE_SPIN: begin
        left_mag       = stage.turn;
        right_mag      = stage.turn;
        left_fwd_next  = stage.turn_right;
        right_fwd_next = !stage.turn_right;
      end
      MODE_SLOW: begin
        if (stage.turn_right) begin
          right_mag = inner;
        end else begin
          left_mag = inner;
        end
      end
      MODE_REVERSE: begin
        if (stage.turn_right) begin
          right_mag      = inner;
          right_fwd_next = !stage.forward;
        end else begin
          left_mag      = inner;
          left_fwd_next = !stage.forward;
        end
      end
      default: begin
      end
    endcase
  end

  // Magnitudes above 127 only occur with a pivot above 63.
  assign left_speed_next  = left_mag[MAG_W-1]  ? '1 : left_mag[WHEEL_W-1:0];
  assign right_speed_next = right_mag[MAG_W-1] ? '1 : right_mag[WHEEL_W-1:0];

  // History of the last delivered values.
  logic               prev_valid;
  logic [WHEEL_W-1:0] prev_left_speed;
  logic [WHEEL_W-1:0] prev_right_speed;
  logic               prev_left_dir;
  logic               prev_right_dir;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_valid <= 1'b0;
    end else if (out_load) begin
      prev_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      prev_left_speed  <= left_speed_next;
      prev_right_speed <= right_speed_next;
      prev_left_dir    <= left_fwd_next;
      prev_right_dir   <= right_fwd_next;
    end
  end

  // Output register.
  logic [19:0] result_next;
  logic [19:0] result;

  assign result_next = {
    !prev_valid || (right_fwd_next != prev_right_dir),
    !prev_valid || (right_speed_next != prev_right_speed),
    !prev_valid || (left_fwd_next != prev_left_dir),
    !prev_valid || (left_speed_next != prev_left_speed),
    right_fwd_next,
    right_speed_next,
    left_fwd_next,
    left_speed_next
  };

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_axis_tvalid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result <= result_next;
    end
  end

  assign m_axis_tdata = {4'b0000, result};

endmodule

[hdl/ddm_const_div.sv]
// ----------------------------------------------------------------------------
// ddm_const_div
// Unsigned divide by a constant, done as a multiply by a rounded-up
// reciprocal and a shift. Exact for every dividend of NumW bits.
// ----------------------------------------------------------------------------
module ddm_const_div
  import ddm_pkg::*;
#(
  parameter int Divisor = PIVOT_DEFAULT,
  parameter int NumW    = NUM_W
) (
  input  logic [NumW-1:0] dividend,
  output logic [NumW-1:0] quotient
);

  // The reciprocal error times the dividend stays below 2^Shift, which
  // keeps the truncated product equal to the exact floor quotient.
  localparam int Shift  = NumW + $clog2(Divisor);
  localparam int MagicW = Shift + 1;
  localparam longint unsigned Magic =
    ((64'd1 << Shift) + longint'(Divisor) - 64'd1) / longint'(Divisor);

  logic [NumW+MagicW-1:0] product;

  assign product  = (NumW+MagicW)'(dividend) * (NumW+MagicW)'(Magic);
  assign quotient = NumW'(product >> Shift);

endmodule
